>>> hdl/bat_pkg.sv
// Breakpoint address table: shared types, command and status codes, entry layout.
// No dependencies; used by breakpoint_address_table.
`default_nettype none
package bat_pkg;

	localparam int BREAK_ENTRIES_DEF = 8;
	localparam int ADDR_W = 24;
	localparam int TIME_W = 32;
	localparam int CNT_W = 32;

	typedef enum logic [2:0] {
		CMD_SET     = 3'd0,
		CMD_DELETE  = 3'd1,
		CMD_CHECK   = 3'd2,
		CMD_HIT     = 3'd3,
		CMD_ENABLE  = 3'd4,
		CMD_CLEAR   = 3'd5,
		CMD_READDR  = 3'd6,
		CMD_READ    = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_MISS   = 2'd1,
		ST_UNUSED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_IDX,
		S_EXEC
	} state_t;

	// one RAM word per entry
	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [TIME_W-1:0] hit_time;
		logic [ADDR_W-1:0] addr;
	} entry_t;

	// input transfer, last field in the low bits
	typedef struct packed {
		logic [TIME_W-1:0] now_time;
		logic              match_any;
		logic              enable_bit;
		logic [2:0]        entry_index;
		logic [ADDR_W-1:0] bp_addr;
		cmd_t              cmd;
	} req_t;

	// output transfer, last field in the low bits, padded to 104 bits
	typedef struct packed {
		logic [6:0]        pad;
		logic [CNT_W-1:0]  rd_count;
		logic [TIME_W-1:0] rd_time;
		logic              rd_enabled;
		logic [ADDR_W-1:0] rd_addr;
		logic              rd_used;
		logic              any_enabled_out;
		logic [2:0]        match_index;
		logic              match_found;
		status_t           status;
	} result_t;

endpackage
`default_nettype wire

>>> hdl/bat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> hdl/breakpoint_address_table.sv
// Address commands (set, delete, check, record hit) pass through the scan, drain and exec
// states; index commands through the index and exec states. The address scan reads one
// entry per cycle through the single read port of the entry RAM and one 24-bit comparator.
// A new command is accepted only in idle; exec waits until the output register is free.
// Reset (arst_n low): sequencer idle, output empty, all used/enable/written bits cleared;
// RAM words not reset, a never-written entry reads as zero.
`default_nettype none
module breakpoint_address_table #(
	parameter int BREAK_ENTRIES = bat_pkg::BREAK_ENTRIES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// s_tdata: cmd[2:0], bp_addr[26:3], entry_index[29:27], enable_bit[30],
	//          match_any[31], now_time[63:32]
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [63:0]  s_tdata,
	// m_tdata: status[1:0], match_found[2], match_index[5:3], any_enabled_out[6],
	//          rd_used[7], rd_addr[31:8], rd_enabled[32], rd_time[64:33],
	//          rd_count[96:65], zero[103:97]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [103:0]      m_tdata
);

	localparam int IW = (BREAK_ENTRIES > 1) ? $clog2(BREAK_ENTRIES) : 1;
	localparam int CW = $clog2(BREAK_ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(BREAK_ENTRIES - 1);
	localparam int EW = $bits(bat_pkg::entry_t);

	bat_pkg::state_t  state_q, state_d;
	bat_pkg::req_t    s_req;
	bat_pkg::req_t    req_q;
	bat_pkg::result_t result_q, result_d;
	logic             out_vld_q;

	logic [BREAK_ENTRIES-1:0] used_q, en_q, wr_q;
	logic [CW-1:0]            cnt_q, cnt_d;

	logic [IW-1:0]   scan_q, chk_idx_q, hit_idx_q, free_idx_q;
	logic            chk_vld_q, hit_vld_q, free_vld_q;
	bat_pkg::entry_t hit_data_q;

	// RAM ports
	logic            ram_we, ram_re;
	logic [IW-1:0]   ram_waddr, ram_raddr;
	bat_pkg::entry_t ram_wdata, rd_entry;
	logic [EW-1:0]   ram_rdata;

	// used/enable flag write
	logic          fl_we, fl_used, fl_en, fl_old;
	logic [IW-1:0] fl_idx;

	logic          accept, out_load, cmp_hit, cmp_free, chk_used;
	logic [IW-1:0] req_idx_w;
	logic          idx_ok;

	assign s_req     = bat_pkg::req_t'(s_tdata);
	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == bat_pkg::S_IDLE);
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = result_q;
	assign rd_entry  = bat_pkg::entry_t'(ram_rdata);
	assign req_idx_w = IW'(req_q.entry_index);
	assign idx_ok    = (32'(req_q.entry_index) < 32'(BREAK_ENTRIES));

	bat_ram #(
		.WIDTH(EW),
		.DEPTH(BREAK_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// scan comparator: one entry per cycle, compared in the cycle after its read address
	always_comb begin
		chk_used = used_q[chk_idx_q];
		cmp_hit  = chk_vld_q && chk_used && (rd_entry.addr == req_q.bp_addr) &&
			((req_q.cmd != bat_pkg::CMD_CHECK) || req_q.match_any || en_q[chk_idx_q]);
		cmp_free = chk_vld_q && !chk_used;
	end

	always_comb begin
		fl_old = used_q[fl_idx] & en_q[fl_idx];
		cnt_d  = cnt_q;
		if (fl_we) begin
			cnt_d = cnt_q - CW'(fl_old) + CW'(fl_used & fl_en);
		end
	end

	// sequencer: next state, RAM control, entry updates and result
	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = scan_q;
		ram_we    = 1'b0;
		ram_waddr = hit_idx_q;
		ram_wdata = hit_data_q;
		fl_we     = 1'b0;
		fl_idx    = hit_idx_q;
		fl_used   = 1'b1;
		fl_en     = req_q.enable_bit;
		out_load  = 1'b0;
		result_d  = '0;
		result_d.status = bat_pkg::ST_MISS;
		case (state_q)
			bat_pkg::S_IDLE: begin
				if (s_tvalid) begin
					if (s_req.cmd[2]) begin
						state_d = bat_pkg::S_IDX;
					end else begin
						state_d = bat_pkg::S_SCAN;
					end
				end
			end
			bat_pkg::S_SCAN: begin
				ram_re = 1'b1;
				if (scan_q == LAST_IDX) begin
					state_d = bat_pkg::S_DRAIN;
				end
			end
			bat_pkg::S_DRAIN: begin
				state_d = bat_pkg::S_EXEC;
			end
			bat_pkg::S_IDX: begin
				ram_re    = idx_ok;
				ram_raddr = req_idx_w;
				state_d   = bat_pkg::S_EXEC;
			end
			bat_pkg::S_EXEC: begin
				if (!out_vld_q || m_tready) begin
					out_load = 1'b1;
					state_d  = bat_pkg::S_IDLE;
					case (req_q.cmd)
						bat_pkg::CMD_SET: begin
							if (hit_vld_q) begin
								fl_we = 1'b1;
								result_d.status      = bat_pkg::ST_OK;
								result_d.match_found = 1'b1;
								result_d.match_index = 3'(hit_idx_q);
							end else if (free_vld_q) begin
								// allocate first free entry
								fl_we     = 1'b1;
								fl_idx    = free_idx_q;
								ram_we    = 1'b1;
								ram_waddr = free_idx_q;
								ram_wdata = '{count: '0, hit_time: '0, addr: req_q.bp_addr};
								result_d.status      = bat_pkg::ST_OK;
								result_d.match_found = 1'b1;
								result_d.match_index = 3'(free_idx_q);
							end
						end
						bat_pkg::CMD_DELETE: begin
							if (hit_vld_q) begin
								fl_we   = 1'b1;
								fl_used = 1'b0;
								fl_en   = en_q[hit_idx_q];
								result_d.status      = bat_pkg::ST_OK;
								result_d.match_found = 1'b1;
								result_d.match_index = 3'(hit_idx_q);
							end
						end
						bat_pkg::CMD_CHECK: begin
							if (hit_vld_q && (cnt_q != '0)) begin
								result_d.status      = bat_pkg::ST_OK;
								result_d.match_found = 1'b1;
								result_d.match_index = 3'(hit_idx_q);
							end
						end
						bat_pkg::CMD_HIT: begin
							if (hit_vld_q) begin
								ram_we    = 1'b1;
								ram_wdata = '{count: hit_data_q.count + 1'b1,
									hit_time: req_q.now_time, addr: hit_data_q.addr};
								result_d.status      = bat_pkg::ST_OK;
								result_d.match_found = 1'b1;
								result_d.match_index = 3'(hit_idx_q);
							end
						end
						default: begin
							// index commands
							result_d.status      = bat_pkg::ST_UNUSED;
							result_d.match_index = req_q.entry_index;
							fl_idx    = req_idx_w;
							ram_waddr = req_idx_w;
							if (req_q.cmd == bat_pkg::CMD_READ && idx_ok) begin
								result_d.rd_used    = used_q[req_idx_w];
								result_d.rd_enabled = en_q[req_idx_w];
								if (wr_q[req_idx_w]) begin
									result_d.rd_addr  = rd_entry.addr;
									result_d.rd_time  = rd_entry.hit_time;
									result_d.rd_count = rd_entry.count;
								end
							end
							if (idx_ok && used_q[req_idx_w]) begin
								result_d.status      = bat_pkg::ST_OK;
								result_d.match_found = 1'b1;
								case (req_q.cmd)
									bat_pkg::CMD_ENABLE: begin
										fl_we = 1'b1;
									end
									bat_pkg::CMD_CLEAR: begin
										ram_we    = 1'b1;
										ram_wdata = '{count: '0, hit_time: '0,
											addr: rd_entry.addr};
									end
									bat_pkg::CMD_READDR: begin
										ram_we    = 1'b1;
										ram_wdata = '{count: rd_entry.count,
											hit_time: rd_entry.hit_time,
											addr: req_q.bp_addr};
									end
									default: begin
									end
								endcase
							end
						end
					endcase
					result_d.any_enabled_out = (cnt_d != '0);
				end
			end
			default: begin
				state_d = bat_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bat_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			used_q     <= '0;
			en_q       <= '0;
			wr_q       <= '0;
			cnt_q      <= '0;
			scan_q     <= '0;
			chk_idx_q  <= '0;
			chk_vld_q  <= 1'b0;
			hit_vld_q  <= 1'b0;
			hit_idx_q  <= '0;
			free_vld_q <= 1'b0;
			free_idx_q <= '0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (fl_we) begin
				used_q[fl_idx] <= fl_used;
				en_q[fl_idx]   <= fl_en;
				cnt_q          <= cnt_d;
			end
			if (ram_we) begin
				wr_q[ram_waddr] <= 1'b1;
			end
			chk_vld_q <= (state_q == bat_pkg::S_SCAN);
			chk_idx_q <= scan_q;
			if (accept) begin
				scan_q     <= '0;
				hit_vld_q  <= 1'b0;
				free_vld_q <= 1'b0;
			end else begin
				if (state_q == bat_pkg::S_SCAN) begin
					scan_q <= scan_q + 1'b1;
				end
				// keep the lowest matching and lowest free index
				if (cmp_hit && !hit_vld_q) begin
					hit_vld_q <= 1'b1;
					hit_idx_q <= chk_idx_q;
				end
				if (cmp_free && !free_vld_q) begin
					free_vld_q <= 1'b1;
					free_idx_q <= chk_idx_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= s_req;
		end
		if (out_load) begin
			result_q <= result_d;
		end
		if (cmp_hit && !hit_vld_q) begin
			hit_data_q <= rd_entry;
		end
	end

	a_cnt_tracks_flags: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) == $countones(used_q & en_q))
		else $error("enabled-entry count out of step with flags");

	a_used_written: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q & ~wr_q) == '0)
		else $error("used entry never written");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		hit_vld_q |-> (32'(hit_idx_q) < 32'(BREAK_ENTRIES)))
		else $error("hit index beyond table");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (result_q.match_found == (result_q.status == bat_pkg::ST_OK)))
		else $error("match_found disagrees with status");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != bat_pkg::S_IDLE) && !s_tready)
		else $error("ready again right after an input transfer");

endmodule
`default_nettype wire

>>> verif/breakpoint_address_table_test.sv
`timescale 1ns / 1ps
// Stream-level test of breakpoint_address_table: directed and random command traffic,
// every result checked against an in-bench copy of the entry table. Needs bat_pkg.
module breakpoint_address_table_test;
	import bat_pkg::*;

	localparam int N_ENTRIES = BREAK_ENTRIES_DEF;
	localparam int N_RANDOM = 1500;
	localparam int LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [103:0] m_tdata;

	bit steady = 1'b0;
	int cycles = 0;
	logic [ADDR_W-1:0] addr_pool [12];

	breakpoint_address_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	class bp_table_tracker;
		bit used [N_ENTRIES];
		logic [ADDR_W-1:0] addr [N_ENTRIES];
		bit enabled [N_ENTRIES];
		logic [TIME_W-1:0] hit_time [N_ENTRIES];
		logic [CNT_W-1:0] hits [N_ENTRIES];
		bit any_en;
		result_t pending_replies [$];
		int errors;
		int n_replies;

		function new();
			for (int i = 0; i < N_ENTRIES; i++) begin
				used[i] = 0;
				addr[i] = '0;
				enabled[i] = 0;
				hit_time[i] = '0;
				hits[i] = '0;
			end
			any_en = 0;
			errors = 0;
			n_replies = 0;
		endfunction

		function int lookup(logic [ADDR_W-1:0] a);
			int found;
			found = -1;
			for (int i = 0; i < N_ENTRIES; i++)
				if (found < 0 && used[i] && addr[i] == a)
					found = i;
			return found;
		endfunction

		function int pending();
			return pending_replies.size();
		endfunction

		// update the table for one accepted command and queue its reply
		function void apply_command(req_t r);
			result_t e;
			int hit;
			int ix;
			e = '0;
			e.status = ST_MISS;
			hit = -1;
			ix = int'(r.entry_index);
			case (r.cmd)
				CMD_SET: begin
					hit = lookup(r.bp_addr);
					if (hit >= 0) begin
						enabled[hit] = r.enable_bit;
					end else begin
						for (int i = 0; i < N_ENTRIES; i++)
							if (hit < 0 && !used[i])
								hit = i;
						if (hit >= 0) begin
							used[hit] = 1;
							addr[hit] = r.bp_addr;
							enabled[hit] = r.enable_bit;
							hit_time[hit] = '0;
							hits[hit] = '0;
						end
					end
				end
				CMD_DELETE: begin
					hit = lookup(r.bp_addr);
					if (hit >= 0)
						used[hit] = 0;
				end
				CMD_CHECK: begin
					// gated by the enabled-any flag from before this command
					if (any_en)
						for (int i = 0; i < N_ENTRIES; i++)
							if (hit < 0 && used[i] && addr[i] == r.bp_addr &&
									(r.match_any || enabled[i]))
								hit = i;
				end
				CMD_HIT: begin
					hit = lookup(r.bp_addr);
					if (hit >= 0) begin
						hit_time[hit] = r.now_time;
						hits[hit] = hits[hit] + 1;
					end
				end
				default: begin
					e.match_index = r.entry_index;
					e.status = ST_UNUSED;
					if (ix < N_ENTRIES) begin
						if (r.cmd == CMD_READ) begin
							e.rd_used = used[ix];
							e.rd_addr = addr[ix];
							e.rd_enabled = enabled[ix];
							e.rd_time = hit_time[ix];
							e.rd_count = hits[ix];
						end
						if (used[ix]) begin
							e.status = ST_OK;
							e.match_found = 1'b1;
							case (r.cmd)
								CMD_ENABLE: enabled[ix] = r.enable_bit;
								CMD_CLEAR: begin
									hit_time[ix] = '0;
									hits[ix] = '0;
								end
								CMD_READDR: addr[ix] = r.bp_addr;
								default: ;
							endcase
						end
					end
				end
			endcase
			// hit is only ever set by the address commands
			if (hit >= 0) begin
				e.status = ST_OK;
				e.match_found = 1'b1;
				e.match_index = hit[2:0];
			end
			any_en = 0;
			for (int i = 0; i < N_ENTRIES; i++)
				if (used[i] && enabled[i])
					any_en = 1;
			e.any_enabled_out = any_en;
			pending_replies.push_back(e);
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endtask

		task cmp(string nm, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("reply %0d: %s is %0h, want %0h", n_replies, nm, got, want));
		endtask

		task check_reply(result_t got);
			result_t want;
			if (pending_replies.size() == 0) begin
				report($sformatf("reply %0d arrived with none outstanding", n_replies));
			end else begin
				want = pending_replies.pop_front();
				cmp("status", 32'(got.status), 32'(want.status));
				cmp("match_found", 32'(got.match_found), 32'(want.match_found));
				cmp("match_index", 32'(got.match_index), 32'(want.match_index));
				cmp("any_enabled_out", 32'(got.any_enabled_out), 32'(want.any_enabled_out));
				cmp("rd_used", 32'(got.rd_used), 32'(want.rd_used));
				cmp("rd_addr", 32'(got.rd_addr), 32'(want.rd_addr));
				cmp("rd_enabled", 32'(got.rd_enabled), 32'(want.rd_enabled));
				cmp("rd_time", got.rd_time, want.rd_time);
				cmp("rd_count", got.rd_count, want.rd_count);
				cmp("pad", 32'(got.pad), 32'(want.pad));
			end
			n_replies++;
		endtask
	endclass

	bp_table_tracker tracker = new();

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady)
			return 0;
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_cmd(cmd_t c, logic [ADDR_W-1:0] a, logic [2:0] ix, logic en,
			logic anym, logic [TIME_W-1:0] t);
		req_t r;
		int gap;
		r.cmd = c;
		r.bp_addr = a;
		r.entry_index = ix;
		r.enable_bit = en;
		r.match_any = anym;
		r.now_time = t;
		s_tdata <= r;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		tracker.apply_command(r);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic cmd_t pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return CMD_SET;
		if (r < 30) return CMD_DELETE;
		if (r < 55) return CMD_CHECK;
		if (r < 70) return CMD_HIT;
		if (r < 78) return CMD_ENABLE;
		if (r < 83) return CMD_CLEAR;
		if (r < 90) return CMD_READDR;
		return CMD_READ;
	endfunction

	function automatic logic [ADDR_W-1:0] pick_addr();
		if ($urandom_range(0, 99) < 85)
			return addr_pool[$urandom_range(0, 11)];
		return ADDR_W'($urandom);
	endfunction

	// result side: check every transfer, stall at random
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				tracker.check_reply(result_t'(m_tdata));
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end
		end
	end

	initial begin
		addr_pool[0] = '0;
		addr_pool[1] = 24'hffffff;
		for (int i = 2; i < 12; i++)
			addr_pool[i] = ADDR_W'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty table: check is gated off, index commands see unused entries
		send_cmd(CMD_CHECK, 24'h000000, 3'd0, 1'b0, 1'b1, 32'h0);
		send_cmd(CMD_READ, 24'h000000, 3'd7, 1'b0, 1'b0, 32'h0);
		send_cmd(CMD_ENABLE, 24'h000000, 3'd3, 1'b1, 1'b0, 32'h0);
		send_cmd(CMD_CLEAR, 24'h000000, 3'd0, 1'b0, 1'b0, 32'h0);
		send_cmd(CMD_READDR, 24'hffffff, 3'd5, 1'b0, 1'b0, 32'h0);
		// disabled entry only: check misses even with match_any; once another entry is enabled, it hits only with match_any
		send_cmd(CMD_SET, 24'h000000, 3'd0, 1'b0, 1'b0, 32'h0);
		send_cmd(CMD_CHECK, 24'h000000, 3'd0, 1'b0, 1'b1, 32'h0);
		send_cmd(CMD_SET, 24'hffffff, 3'd0, 1'b1, 1'b0, 32'h0);
		send_cmd(CMD_CHECK, 24'h000000, 3'd0, 1'b0, 1'b0, 32'h0);
		send_cmd(CMD_CHECK, 24'h000000, 3'd0, 1'b0, 1'b1, 32'h0);
		// record hit on a disabled entry, time extremes, and a miss
		send_cmd(CMD_HIT, 24'h000000, 3'd0, 1'b0, 1'b0, 32'hffffffff);
		send_cmd(CMD_HIT, 24'h000000, 3'd0, 1'b0, 1'b0, 32'h00000000);
		send_cmd(CMD_HIT, 24'h123456, 3'd0, 1'b0, 1'b0, 32'h5a5a5a5a);
		send_cmd(CMD_READ, 24'h000000, 3'd0, 1'b0, 1'b0, 32'h0);
		// fill the table, then set on a full table
		for (int i = 0; i < N_ENTRIES - 2; i++)
			send_cmd(CMD_SET, ADDR_W'(24'h111111 * (i + 1)), 3'd0, i[0], 1'b0, 32'h0);
		send_cmd(CMD_SET, 24'h800000, 3'd0, 1'b1, 1'b0, 32'h0);
		// duplicate address by readdress: lowest index wins
		send_cmd(CMD_READDR, 24'hffffff, 3'd2, 1'b0, 1'b0, 32'h0);
		send_cmd(CMD_CHECK, 24'hffffff, 3'd0, 1'b0, 1'b1, 32'h0);
		send_cmd(CMD_DELETE, 24'hffffff, 3'd0, 1'b0, 1'b0, 32'h0);
		send_cmd(CMD_READ, 24'h000000, 3'd1, 1'b0, 1'b0, 32'h0);
		send_cmd(CMD_DELETE, 24'hffffff, 3'd0, 1'b0, 1'b0, 32'h0);
		send_cmd(CMD_DELETE, 24'hffffff, 3'd0, 1'b0, 1'b0, 32'h0);
		send_cmd(CMD_ENABLE, 24'h000000, 3'd0, 1'b1, 1'b0, 32'h0);
		send_cmd(CMD_CLEAR, 24'h000000, 3'd0, 1'b0, 1'b0, 32'h0);
		send_cmd(CMD_READ, 24'h000000, 3'd0, 1'b0, 1'b0, 32'h0);
		send_cmd(CMD_SET, 24'h000000, 3'd0, 1'b0, 1'b0, 32'h0);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 250 == 0)
				steady = ($urandom_range(0, 2) == 0);
			if (n % 300 == 299)
				addr_pool[$urandom_range(2, 11)] = ADDR_W'($urandom);
			send_cmd(pick_cmd(), pick_addr(), 3'($urandom_range(0, 7)), 1'($urandom),
				1'($urandom), $urandom);
		end
		s_tvalid <= 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> sim.f
hdl/bat_pkg.sv
hdl/bat_ram.sv
hdl/breakpoint_address_table.sv
verif/breakpoint_address_table_test.sv
